// ===== hdl/cphp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster position package
// Shared types, register indexes, command codes and widths of the cluster
// position unit.
// ----------------------------------------------------------------------------
package cphp_pkg;

    localparam int LAYER_COUNT_DEF      = 128;
    localparam int STRIP_COUNT_DEF      = 32;
    localparam int WEIGHT_FRAC_BITS_DEF = 34;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int OUT_W      = 20;
    localparam int ACC_W      = 64;
    localparam int MID_W      = 27;
    localparam int HW_W       = 17;
    localparam int CTR_W      = 42;
    localparam int STEP_W     = 6;
    localparam int ERR_W      = 21;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCINT_THICKNESS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_WIDTH        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_PITCH        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMING_UNCERTAINTY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_LAYER_ORIGIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LAYER_ORIGIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_STRIP_ORIGIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_STRIP_ORIGIN  = 3'd7;

    // Calorimeter sections.
    localparam logic [2:0] SEC_BACK   = 3'd0;
    localparam logic [2:0] SEC_TOP    = 3'd1;
    localparam logic [2:0] SEC_BOTTOM = 3'd2;
    localparam logic [2:0] SEC_LEFT   = 3'd3;
    localparam logic [2:0] SEC_RIGHT  = 3'd4;

    // Axes.
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // Datapath commands.
    typedef logic [4:0] t_op;
    localparam t_op OP_NOP       = 5'd0;
    localparam t_op OP_LATCH     = 5'd1;
    localparam t_op OP_PREP      = 5'd2;
    localparam t_op OP_SQ        = 5'd3;
    localparam t_op OP_WDIV_INIT = 5'd4;
    localparam t_op OP_DIV_STEP  = 5'd5;
    localparam t_op OP_MUL_INIT  = 5'd6;
    localparam t_op OP_MUL_STEP  = 5'd7;
    localparam t_op OP_ACCUM     = 5'd8;
    localparam t_op OP_CDIV_INIT = 5'd9;
    localparam t_op OP_CENTER    = 5'd10;
    localparam t_op OP_EDIV_INIT = 5'd11;
    localparam t_op OP_SQRT_INIT = 5'd12;
    localparam t_op OP_SQRT_STEP = 5'd13;
    localparam t_op OP_STORE     = 5'd14;
    localparam t_op OP_ZERO_AXIS = 5'd15;
    localparam t_op OP_OUT_LOAD  = 5'd16;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
    } t_ctl;

    typedef struct packed {
        logic hit_bad;
        logic last;
        logic wt_zero;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [2:0]              section;
        logic [6:0]              hit_layer;
        logic [4:0]              hit_strip;
        logic signed [OUT_W-1:0] hit_x;
        logic signed [OUT_W-1:0] hit_y;
        logic                    last_hit;
    } t_hit;

    typedef struct packed {
        logic signed [OUT_W-1:0] x_low;
        logic signed [OUT_W-1:0] x_high;
        logic signed [OUT_W-1:0] y_low;
        logic signed [OUT_W-1:0] y_high;
        logic signed [OUT_W-1:0] z_low;
        logic signed [OUT_W-1:0] z_high;
        logic                    bad_hit;
    } t_pos;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg;

endpackage

// ===== hdl/cphp_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster position channels
// Valid/ready channels for hits, configuration writes and results.
// ----------------------------------------------------------------------------
interface cphp_hit_if import cphp_pkg::*; ();
    logic valid;
    logic ready;
    t_hit data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cphp_cfg_if import cphp_pkg::*; ();
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cphp_pos_if import cphp_pkg::*; ();
    logic valid;
    logic ready;
    t_pos data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cphp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster position datapath
// Box geometry, shared restoring divider, serial multiplier, square root
// and per-axis accumulators.
// ----------------------------------------------------------------------------
module cphp_dp import cphp_pkg::*; #(
    parameter int LAYER_COUNT      = LAYER_COUNT_DEF,
    parameter int STRIP_COUNT      = STRIP_COUNT_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_hit i_hit_data,
    input  logic i_cfg_we,
    input  t_cfg i_cfg_data,
    input  t_ctl i_ctl,
    output t_sts o_sts,
    output logic o_pos_valid,
    output t_pos o_pos_data,
    input  logic i_pos_ready
);

    localparam int WB = WEIGHT_FRAC_BITS + 3;

    logic [15:0] r_scint, r_sw, r_pitch, r_tu;
    logic [16:0] r_blo, r_slo, r_bso, r_sso;
    t_hit        r_hit;
    logic [23:0] r_lc2;
    logic [22:0] r_sc2;
    logic signed [MID_W-1:0] r_m;
    logic [2*HW_W-1:0] r_h2;
    logic [ACC_W:0]    r_rem;
    logic [ACC_W-1:0]  r_quo, r_dvs;
    logic [ACC_W-1:0]  r_mcand, r_prod;
    logic [WB-1:0]     r_mplier, r_w;
    logic [ACC_W-1:0]  r_wt [0:2];
    logic [ACC_W-1:0]  r_mt [0:2];
    logic              r_neg;
    logic signed [CTR_W-1:0] r_c;
    logic [ACC_W-1:0]  r_sx, r_sr, r_sbit;
    logic signed [OUT_W-1:0] r_lo [0:2];
    logic signed [OUT_W-1:0] r_hi [0:2];
    logic r_bad_seen, r_fin_bad, r_ov;
    t_pos r_pos;

    logic hit_bad;
    logic signed [MID_W-1:0] x2, y2, back_y, back_z, lay, side_z, m_sel;
    logic [HW_W-1:0] tu2, th, sw, h_sel, h_eff;
    logic [22:0] lp;
    logic [ACC_W:0] rem_s;
    logic [ACC_W-1:0] mid_a, mag, qq, q, sr_t;
    logic signed [ACC_W-1:0] c_full;
    logic signed [CTR_W:0] c_ext, e_ext;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [CTR_W:0] v);
        if (v < -(CTR_W+1)'(524288)) begin
            sat_out = OUT_W'(-(CTR_W+1)'(524288));
        end else if (v > (CTR_W+1)'(524287)) begin
            sat_out = OUT_W'(524287);
        end else begin
            sat_out = OUT_W'(v);
        end
    endfunction

    assign hit_bad = (r_hit.section > SEC_RIGHT)
                   || (32'(r_hit.hit_layer) >= 32'(LAYER_COUNT))
                   || (32'(r_hit.hit_strip) >= 32'(STRIP_COUNT));

    assign lp = 23'(r_hit.hit_layer) * 23'(r_pitch);

    // Midpoints and half-widths in 1/32 mm.
    always_comb begin
        x2     = MID_W'(r_hit.hit_x) <<< 1;
        y2     = MID_W'(r_hit.hit_y) <<< 1;
        back_y = MID_W'({r_bso, 1'b0}) + MID_W'(r_sc2);
        back_z = MID_W'({r_blo, 1'b0}) + MID_W'(r_lc2);
        side_z = MID_W'({r_sso, 1'b0}) + MID_W'(r_sc2);
        if (r_hit.section == SEC_TOP || r_hit.section == SEC_LEFT) begin
            lay = MID_W'({r_slo, 1'b0}) + MID_W'(r_lc2);
        end else begin
            lay = MID_W'({r_slo, 1'b0}) - MID_W'(r_lc2);
        end
        tu2 = {r_tu, 1'b0};
        th  = HW_W'(r_scint);
        sw  = HW_W'(r_sw);
        h_sel = th;
        m_sel = side_z;
        case (i_ctl.axis)
            AX_X: begin
                if (r_hit.section == SEC_LEFT || r_hit.section == SEC_RIGHT) begin
                    h_sel = th;
                    m_sel = lay;
                end else begin
                    h_sel = tu2;
                    m_sel = x2;
                end
            end
            AX_Y: begin
                if (r_hit.section == SEC_BACK) begin
                    h_sel = sw;
                    m_sel = back_y;
                end else if (r_hit.section == SEC_LEFT || r_hit.section == SEC_RIGHT) begin
                    h_sel = tu2;
                    m_sel = y2;
                end else begin
                    h_sel = th;
                    m_sel = lay;
                end
            end
            default: begin
                if (r_hit.section == SEC_BACK) begin
                    h_sel = th;
                    m_sel = back_z;
                end else begin
                    h_sel = sw;
                    m_sel = side_z;
                end
            end
        endcase
        h_eff = (h_sel == '0) ? HW_W'(1) : h_sel;
    end

    always_comb begin
        rem_s  = {r_rem[ACC_W-1:0], r_quo[ACC_W-1]};
        mid_a  = r_mt[i_ctl.axis];
        mag    = mid_a[ACC_W-1] ? (ACC_W'(0) - mid_a) : mid_a;
        qq     = r_quo + ACC_W'(r_neg && (r_rem != '0));
        q      = r_neg ? (ACC_W'(0) - qq) : qq;
        c_full = $signed(q) >>> 1;
        sr_t   = r_sr + r_sbit;
        c_ext  = (CTR_W+1)'(r_c);
        e_ext  = (CTR_W+1)'(r_sr[ERR_W-1:0]);
    end

    assign o_sts.hit_bad  = hit_bad;
    assign o_sts.last     = r_hit.last_hit;
    assign o_sts.wt_zero  = (r_wt[i_ctl.axis] == '0);
    assign o_sts.out_free = !r_ov || i_pos_ready;
    assign o_pos_valid    = r_ov;
    assign o_pos_data     = r_pos;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scint <= 16'd240;
            r_sw    <= 16'd1600;
            r_pitch <= 16'd704;
            r_tu    <= 16'd1600;
            r_blo   <= 17'd8000;
            r_slo   <= 17'd4200;
            r_bso   <= 17'd24000;
            r_sso   <= 17'd3200;
        end else if (i_cfg_we) begin
            case (i_cfg_data.index)
                REG_SCINT_THICKNESS:    r_scint <= i_cfg_data.wdata[15:0];
                REG_STRIP_WIDTH:        r_sw    <= i_cfg_data.wdata[15:0];
                REG_LAYER_PITCH:        r_pitch <= i_cfg_data.wdata[15:0];
                REG_TIMING_UNCERTAINTY: r_tu    <= i_cfg_data.wdata[15:0];
                REG_BACK_LAYER_ORIGIN:  r_blo   <= i_cfg_data.wdata;
                REG_SIDE_LAYER_ORIGIN:  r_slo   <= i_cfg_data.wdata;
                REG_BACK_STRIP_ORIGIN:  r_bso   <= i_cfg_data.wdata;
                REG_SIDE_STRIP_ORIGIN:  r_sso   <= i_cfg_data.wdata;
                default: ;
            endcase
        end
    end

    // Cluster state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_wt[a] <= '0;
                r_mt[a] <= '0;
            end
            r_bad_seen <= 1'b0;
            r_fin_bad  <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            // A new result may replace one that leaves in the same cycle.
            if (i_ctl.op == OP_OUT_LOAD) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_pos_ready) begin
                r_ov <= 1'b0;
            end
            case (i_ctl.op)
                OP_PREP: begin
                    if (hit_bad) begin
                        r_bad_seen <= 1'b1;
                    end
                end
                OP_ACCUM: begin
                    r_wt[i_ctl.axis] <= r_wt[i_ctl.axis] + ACC_W'(r_w);
                    r_mt[i_ctl.axis] <= r_mt[i_ctl.axis] + r_prod;
                end
                OP_ZERO_AXIS: r_fin_bad <= 1'b1;
                OP_OUT_LOAD: begin
                    for (int a = 0; a < 3; a++) begin
                        r_wt[a] <= '0;
                        r_mt[a] <= '0;
                    end
                    r_bad_seen <= 1'b0;
                    r_fin_bad  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Arithmetic working registers.
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_LATCH: r_hit <= i_hit_data;
            OP_PREP: begin
                r_lc2 <= 24'({lp, 1'b0}) + 24'(r_scint);
                r_sc2 <= 23'({r_hit.hit_strip, 1'b1}) * 23'(r_sw);
            end
            OP_SQ: begin
                r_h2 <= (2*HW_W)'(h_eff) * (2*HW_W)'(h_eff);
                r_m  <= m_sel;
            end
            OP_WDIV_INIT: begin
                r_rem <= '0;
                r_quo <= ACC_W'(1) << (WEIGHT_FRAC_BITS + 2);
                r_dvs <= ACC_W'(r_h2);
            end
            OP_DIV_STEP: begin
                if (rem_s >= {1'b0, r_dvs}) begin
                    r_rem <= rem_s - {1'b0, r_dvs};
                    r_quo <= {r_quo[ACC_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_s;
                    r_quo <= {r_quo[ACC_W-2:0], 1'b0};
                end
            end
            OP_MUL_INIT: begin
                r_w      <= r_quo[WB-1:0];
                r_mplier <= r_quo[WB-1:0];
                r_mcand  <= ACC_W'(r_m);
                r_prod   <= '0;
            end
            OP_MUL_STEP: begin
                if (r_mplier[0]) begin
                    r_prod <= r_prod + r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
            end
            OP_CDIV_INIT: begin
                r_neg <= mid_a[ACC_W-1];
                r_rem <= '0;
                r_quo <= mag;
                r_dvs <= r_wt[i_ctl.axis];
            end
            OP_CENTER: begin
                if (c_full > ACC_W'(64'sd1 <<< 40)) begin
                    r_c <= CTR_W'(64'sd1 <<< 40);
                end else if (c_full < -(ACC_W'(64'sd1 <<< 40))) begin
                    r_c <= -CTR_W'(64'sd1 <<< 40);
                end else begin
                    r_c <= CTR_W'(c_full);
                end
            end
            OP_EDIV_INIT: begin
                r_rem <= '0;
                r_quo <= ACC_W'(1) << WEIGHT_FRAC_BITS;
                r_dvs <= r_wt[i_ctl.axis];
            end
            OP_SQRT_INIT: begin
                r_sx   <= r_quo;
                r_sr   <= '0;
                r_sbit <= ACC_W'(1) << (ACC_W - 2);
            end
            OP_SQRT_STEP: begin
                if (r_sx >= sr_t) begin
                    r_sx <= r_sx - sr_t;
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            OP_STORE: begin
                r_lo[i_ctl.axis] <= sat_out(c_ext - e_ext);
                r_hi[i_ctl.axis] <= sat_out(c_ext + e_ext);
            end
            OP_ZERO_AXIS: begin
                r_lo[i_ctl.axis] <= '0;
                r_hi[i_ctl.axis] <= '0;
            end
            OP_OUT_LOAD: begin
                r_pos.x_low   <= r_lo[AX_X];
                r_pos.x_high  <= r_hi[AX_X];
                r_pos.y_low   <= r_lo[AX_Y];
                r_pos.y_high  <= r_hi[AX_Y];
                r_pos.z_low   <= r_lo[AX_Z];
                r_pos.z_high  <= r_hi[AX_Z];
                r_pos.bad_hit <= r_bad_seen || r_fin_bad;
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/cphp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster position controller
// Sequences hit accumulation and the per-axis finish through the datapath.
// ----------------------------------------------------------------------------
module cphp_ctrl import cphp_pkg::*; #(
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_hit_valid,
    output logic o_hit_ready,
    output t_ctl o_ctl,
    input  t_sts i_sts
);

    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(ACC_W - 1);
    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(WEIGHT_FRAC_BITS + 2);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ACC_W / 2 - 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_PREP   = 5'd1;
    localparam logic [4:0] S_SQ     = 5'd2;
    localparam logic [4:0] S_WINIT  = 5'd3;
    localparam logic [4:0] S_WDIV   = 5'd4;
    localparam logic [4:0] S_MINIT  = 5'd5;
    localparam logic [4:0] S_MUL    = 5'd6;
    localparam logic [4:0] S_ACC    = 5'd7;
    localparam logic [4:0] S_FIN    = 5'd8;
    localparam logic [4:0] S_CDIV   = 5'd9;
    localparam logic [4:0] S_CENTER = 5'd10;
    localparam logic [4:0] S_EINIT  = 5'd11;
    localparam logic [4:0] S_EDIV   = 5'd12;
    localparam logic [4:0] S_SINIT  = 5'd13;
    localparam logic [4:0] S_SQRT   = 5'd14;
    localparam logic [4:0] S_STORE  = 5'd15;
    localparam logic [4:0] S_OUT    = 5'd16;

    logic [4:0]        r_state, n_state;
    logic [1:0]        r_axis, n_axis;
    logic [STEP_W-1:0] r_step, n_step;

    assign o_hit_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_step     = r_step;
        o_ctl.op   = OP_NOP;
        o_ctl.axis = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_hit_valid) begin
                    o_ctl.op = OP_LATCH;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                o_ctl.op = OP_PREP;
                n_axis   = AX_X;
                if (!i_sts.hit_bad) begin
                    n_state = S_SQ;
                end else if (i_sts.last) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SQ: begin
                o_ctl.op = OP_SQ;
                n_state  = S_WINIT;
            end
            S_WINIT: begin
                o_ctl.op = OP_WDIV_INIT;
                n_state  = S_WDIV;
            end
            S_WDIV: begin
                o_ctl.op = OP_DIV_STEP;
                n_step   = r_step + 1'b1;
                if (r_step == DIV_LAST) begin
                    n_step  = '0;
                    n_state = S_MINIT;
                end
            end
            S_MINIT: begin
                o_ctl.op = OP_MUL_INIT;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_ctl.op = OP_MUL_STEP;
                n_step   = r_step + 1'b1;
                if (r_step == MUL_LAST) begin
                    n_step  = '0;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_ctl.op = OP_ACCUM;
                if (r_axis != AX_Z) begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_SQ;
                end else begin
                    n_axis  = AX_X;
                    n_state = i_sts.last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (i_sts.wt_zero) begin
                    o_ctl.op = OP_ZERO_AXIS;
                    if (r_axis != AX_Z) begin
                        n_axis = r_axis + 1'b1;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    o_ctl.op = OP_CDIV_INIT;
                    n_state  = S_CDIV;
                end
            end
            S_CDIV: begin
                o_ctl.op = OP_DIV_STEP;
                n_step   = r_step + 1'b1;
                if (r_step == DIV_LAST) begin
                    n_step  = '0;
                    n_state = S_CENTER;
                end
            end
            S_CENTER: begin
                o_ctl.op = OP_CENTER;
                n_state  = S_EINIT;
            end
            S_EINIT: begin
                o_ctl.op = OP_EDIV_INIT;
                n_state  = S_EDIV;
            end
            S_EDIV: begin
                o_ctl.op = OP_DIV_STEP;
                n_step   = r_step + 1'b1;
                if (r_step == DIV_LAST) begin
                    n_step  = '0;
                    n_state = S_SINIT;
                end
            end
            S_SINIT: begin
                o_ctl.op = OP_SQRT_INIT;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_ctl.op = OP_SQRT_STEP;
                n_step   = r_step + 1'b1;
                if (r_step == SQRT_LAST) begin
                    n_step  = '0;
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_ctl.op = OP_STORE;
                if (r_axis != AX_Z) begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.op = OP_OUT_LOAD;
                    n_axis   = AX_X;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= AX_X;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_step  <= n_step;
        end
    end

endmodule

// ===== hdl/calorimeter_hit_cluster_position_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calorimeter hit cluster position unit
// Reduces the hits of one cluster to a weighted box in x, y and z.
// ----------------------------------------------------------------------------
// Sequence: a good hit runs weight division, multiply and accumulate per
// axis, a skipped hit only its latch and check; the last hit adds the
// per-axis finish (a zeroing for an unweighted axis) and the result load.
// Throughput: one hit word at a time, set by the shared one-bit-per-cycle
// divider (64 steps) and the serial weight multiplier.
// Reset: synchronous, active low; clears the cluster sums, the flags and
// the result valid and restores the configuration defaults.
module calorimeter_hit_cluster_position_unit import cphp_pkg::*; #(
    parameter int LAYER_COUNT      = LAYER_COUNT_DEF,
    parameter int STRIP_COUNT      = STRIP_COUNT_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cphp_hit_if.sink   i_hit,
    cphp_cfg_if.sink   i_cfg,
    cphp_pos_if.source o_pos
);

    t_ctl ctl;
    t_sts sts;

    // Configuration writes go straight into the registers, so the port never stalls.
    assign i_cfg.ready = 1'b1;

    // The controller walks each hit through the three axes: a weight from a
    // restoring division of 2^(F+2) by the squared half-width, a serial
    // multiply of that weight by the midpoint, then the accumulate. On the
    // last hit of a cluster it runs the center division, the error division
    // and the square root per weighted axis before loading the result register.
    cphp_ctrl #(
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hit_valid (i_hit.valid),
        .o_hit_ready (i_hit.ready),
        .o_ctl       (ctl),
        .i_sts       (sts)
    );

    // The datapath holds the result in its own register, so a new cluster
    // can start while the previous result still waits downstream.
    cphp_dp #(
        .LAYER_COUNT      (LAYER_COUNT),
        .STRIP_COUNT      (STRIP_COUNT),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hit_data  (i_hit.data),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_pos_valid (o_pos.valid),
        .o_pos_data  (o_pos.data),
        .i_pos_ready (o_pos.ready)
    );

endmodule

// ===== hdl/cphp_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster position checker
// Port-level checks of the cluster position unit, bound to the top level.
// ----------------------------------------------------------------------------
module cphp_chk import cphp_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_hit_valid,
    input logic i_hit_ready,
    input logic i_pos_valid,
    input logic i_pos_ready,
    input t_pos i_pos_data
);

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_pos_valid)
        else $error("result valid after reset");

    // The unit leaves idle when it takes a hit word, so ready drops after a take.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hit_valid && i_hit_ready |=> !i_hit_ready)
        else $error("hit taken while busy");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pos_valid && !i_pos_ready |=> i_pos_valid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pos_valid && !i_pos_ready |=> $stable(i_pos_data))
        else $error("result changed while stalled");

endmodule

bind calorimeter_hit_cluster_position_unit cphp_chk u_cphp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_hit_valid (i_hit.valid),
    .i_hit_ready (i_hit.ready),
    .i_pos_valid (o_pos.valid),
    .i_pos_ready (o_pos.ready),
    .i_pos_data  (o_pos.data)
);

// ===== verif/calorimeter_hit_cluster_position_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calorimeter hit cluster position unit testbench
// Streams clusters of calorimeter hits into the unit under several register
// settings. A predictor folds every accepted in-range hit into per-axis sums.
// Each cluster box that it predicts is checked field by field against the
// result words. The sender works in bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module calorimeter_hit_cluster_position_unit_tb;
    import cphp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 700;
    localparam int LONG_HOLD      = 4000;

    logic i_clk;
    logic i_rst_n;

    cphp_hit_if hit_ch ();
    cphp_cfg_if cfg_ch ();
    cphp_pos_if pos_ch ();

    calorimeter_hit_cluster_position_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hit   (hit_ch),
        .i_cfg   (cfg_ch),
        .o_pos   (pos_ch)
    );

    // Predictor state: a copy of the register file and the cluster sums.
    logic [CFG_DATA_W-1:0] reg_file [8];
    longint unsigned       weight_sum [3];
    longint unsigned       mid_sum [3];
    int                    good_hits;
    bit                    skipped_hit;

    t_hit hit_backlog [$];
    t_pos cluster_boxes [$];

    int  mismatches;
    int  idle_cycles;
    bit  hit_taken;
    bit  hold_request;
    bit  hold_done;
    int  hold_left;
    int  burst_left;
    int  gap_left;
    int  ready_mode;
    int  mode_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Half-width and midpoint arrive in 1/32 mm.
    function automatic void add_box_side(int a, longint unsigned h, longint m);
        longint unsigned w;
        if (h == 0) h = 1;
        w = (64'd1 << (WEIGHT_FRAC_BITS_DEF + 2)) / (h * h);
        weight_sum[a] += w;
        mid_sum[a] += w * longint'(m);
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
        if (v < -524288) v = -524288;
        if (v > 524287) v = 524287;
        return v[OUT_W-1:0];
    endfunction

    function automatic bit axis_bounds(int a, output logic signed [OUT_W-1:0] lo,
                                       output logic signed [OUT_W-1:0] hi);
        longint unsigned wt, mid, q, qq, mag, e;
        longint c;
        lo = '0;
        hi = '0;
        wt = weight_sum[a];
        mid = mid_sum[a];
        if (wt == 0) return 1'b0;
        // Negative sums round toward minus infinity, like a floor.
        if (mid[63]) begin
            mag = -mid;
            qq = mag / wt;
            if (mag % wt != 0) qq++;
            q = -qq;
        end else begin
            q = mid / wt;
        end
        q = {q[63], q[63:1]};
        c = longint'(q);
        if (c > (64'sd1 <<< 40)) c = 64'sd1 <<< 40;
        if (c < -(64'sd1 <<< 40)) c = -(64'sd1 <<< 40);
        e = int_sqrt((64'd1 << WEIGHT_FRAC_BITS_DEF) / wt);
        lo = clamp_out(c - longint'(e));
        hi = clamp_out(c + longint'(e));
        return 1'b1;
    endfunction

    function automatic void fold_hit(t_hit h);
        longint x2, y2, lc2, sc2, lay;
        longint unsigned th2, sw2, tu2;
        t_pos box;
        bit flag;
        x2 = 2 * longint'(h.hit_x);
        y2 = 2 * longint'(h.hit_y);
        if (h.section > SEC_RIGHT || int'(h.hit_layer) >= LAYER_COUNT_DEF
            || int'(h.hit_strip) >= STRIP_COUNT_DEF) begin
            skipped_hit = 1'b1;
        end else begin
            th2 = longint'(reg_file[REG_SCINT_THICKNESS]);
            sw2 = longint'(reg_file[REG_STRIP_WIDTH]);
            tu2 = 2 * longint'(reg_file[REG_TIMING_UNCERTAINTY]);
            lc2 = 2 * longint'(h.hit_layer) * longint'(reg_file[REG_LAYER_PITCH])
                  + longint'(th2);
            sc2 = (2 * longint'(h.hit_strip) + 1) * longint'(sw2);
            if (h.section == SEC_BACK) begin
                add_box_side(AX_X, tu2, x2);
                add_box_side(AX_Y, sw2, 2 * longint'(reg_file[REG_BACK_STRIP_ORIGIN]) + sc2);
                add_box_side(AX_Z, th2, 2 * longint'(reg_file[REG_BACK_LAYER_ORIGIN]) + lc2);
            end else begin
                // Top and left grow away from the origin, bottom and right toward it.
                if (h.section == SEC_TOP || h.section == SEC_LEFT)
                    lay = 2 * longint'(reg_file[REG_SIDE_LAYER_ORIGIN]) + lc2;
                else
                    lay = 2 * longint'(reg_file[REG_SIDE_LAYER_ORIGIN]) - lc2;
                if (h.section == SEC_TOP || h.section == SEC_BOTTOM) begin
                    add_box_side(AX_X, tu2, x2);
                    add_box_side(AX_Y, th2, lay);
                end else begin
                    add_box_side(AX_X, th2, lay);
                    add_box_side(AX_Y, tu2, y2);
                end
                add_box_side(AX_Z, sw2, 2 * longint'(reg_file[REG_SIDE_STRIP_ORIGIN]) + sc2);
            end
            if (good_hits < 255) good_hits++;
        end
        if (!h.last_hit) return;
        box = '0;
        flag = skipped_hit;
        if (good_hits == 0) begin
            flag = 1'b1;
        end else begin
            if (!axis_bounds(AX_X, box.x_low, box.x_high)) flag = 1'b1;
            if (!axis_bounds(AX_Y, box.y_low, box.y_high)) flag = 1'b1;
            if (!axis_bounds(AX_Z, box.z_low, box.z_high)) flag = 1'b1;
        end
        box.bad_hit = flag;
        cluster_boxes.insert(cluster_boxes.size(), box);
        for (int a = 0; a < 3; a++) begin
            weight_sum[a] = 0;
            mid_sum[a] = 0;
        end
        good_hits = 0;
        skipped_hit = 1'b0;
    endfunction

    function automatic void check_box(t_pos got);
        t_pos want;
        longint w [7];
        longint g [7];
        if (cluster_boxes.size() == 0) begin
            $display("%0t: result word with no cluster pending: %p", $time, got);
            mismatches++;
            return;
        end
        want = cluster_boxes.pop_front();
        w = '{want.x_low, want.x_high, want.y_low, want.y_high, want.z_low, want.z_high,
              want.bad_hit};
        g = '{got.x_low, got.x_high, got.y_low, got.y_high, got.z_low, got.z_high,
              got.bad_hit};
        for (int f = 0; f < 7; f++) begin
            if (w[f] != g[f]) begin
                $display("%0t: field %0d of result: expected %0d, actual %0d",
                         $time, f, w[f], g[f]);
                mismatches++;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor and watchdog, both working on the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        hit_taken <= hit_ch.valid && hit_ch.ready;
        if (i_rst_n && hit_ch.valid && hit_ch.ready) fold_hit(hit_ch.data);
        if (i_rst_n && pos_ch.valid && pos_ch.ready) check_box(pos_ch.data);
        if (!i_rst_n || (hit_ch.valid && hit_ch.ready) || (pos_ch.valid && pos_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("calorimeter_hit_cluster_position_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Hit driver: bursts of words separated by random gaps.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!hit_ch.valid || hit_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                hit_ch.valid <= 1'b0;
            end else if (hit_backlog.size() > 0) begin
                hit_ch.valid <= 1'b1;
                hit_ch.data <= hit_backlog.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                hit_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: switches between always ready, light and heavy stalls,
    // and takes one long hold when asked so that the unit backs up.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pos_ch.ready <= 1'b0;
            hold_left <= 0;
            mode_left <= 0;
        end else if (hold_request && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            pos_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pos_ch.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(50, 400);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: begin
                    pos_ch.ready <= 1'b1;
                end
                1: begin
                    pos_ch.ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    pos_ch.ready <= ($urandom_range(0, 7) == 0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void stage_hit(t_hit h);
        hit_backlog.insert(hit_backlog.size(), h);
    endfunction

    function automatic t_hit make_hit(logic [2:0] sec, int layer, int strip,
                                      logic signed [OUT_W-1:0] x,
                                      logic signed [OUT_W-1:0] y, bit last);
        t_hit h;
        h.section = sec;
        h.hit_layer = layer[6:0];
        h.hit_strip = strip[4:0];
        h.hit_x = x;
        h.hit_y = y;
        h.last_hit = last;
        return h;
    endfunction

    function automatic logic signed [OUT_W-1:0] pick_coord();
        int r;
        int v;
        r = $urandom_range(0, 19);
        if (r < 14) begin
            v = $urandom_range(0, 40000);
            return OUT_W'(v - 20000);
        end
        if (r < 17) return OUT_W'($urandom());
        if (r == 17) return -20'sd524288;
        if (r == 18) return 20'sd524287;
        return '0;
    endfunction

    // Mostly well-formed clusters; a tenth of the hits land in an unknown section.
    task automatic queue_random_clusters(int count);
        int added;
        int n;
        logic [2:0] sec;
        added = 0;
        while (added < count) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0) sec = 3'($urandom_range(5, 7));
                else sec = 3'($urandom_range(0, 4));
                stage_hit(make_hit(sec, $urandom_range(0, 127),
                    $urandom_range(0, 31), pick_coord(), pick_coord(), k == n - 1));
            end
            added += n;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data.index = idx;
        cfg_ch.data.wdata = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        // The thickness, width, pitch and timing registers hold 16 bits.
        if (idx <= REG_TIMING_UNCERTAINTY) reg_file[idx] = {1'b0, value[15:0]};
        else reg_file[idx] = value;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic write_all(int lengths [4], int origins [4]);
        write_reg(REG_SCINT_THICKNESS, 17'(lengths[0]));
        write_reg(REG_STRIP_WIDTH, 17'(lengths[1]));
        write_reg(REG_LAYER_PITCH, 17'(lengths[2]));
        write_reg(REG_TIMING_UNCERTAINTY, 17'(lengths[3]));
        write_reg(REG_BACK_LAYER_ORIGIN, 17'(origins[0]));
        write_reg(REG_SIDE_LAYER_ORIGIN, 17'(origins[1]));
        write_reg(REG_BACK_STRIP_ORIGIN, 17'(origins[2]));
        write_reg(REG_SIDE_STRIP_ORIGIN, 17'(origins[3]));
    endtask

    // Waits until every hit went in and every box came out, then lets the
    // unit finish its last cluster before anything else happens.
    task automatic drain();
        while (hit_backlog.size() > 0 || hit_ch.valid || cluster_boxes.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        hit_ch.valid = 1'b0;
        hit_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        pos_ch.ready = 1'b0;
        reg_file = '{240, 1600, 704, 1600, 8000, 4200, 24000, 3200};
        weight_sum = '{0, 0, 0};
        mid_sum = '{0, 0, 0};
        good_hits = 0;
        skipped_hit = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        hit_taken = 1'b0;
        hold_request = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        burst_left = 1;
        gap_left = 0;
        ready_mode = 0;
        mode_left = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed clusters under the reset settings: one per section, all
        // five sections together, unknown sections mixed with good hits, an
        // empty cluster, and the extremes of layer, strip and position.
        stage_hit(make_hit(SEC_BACK, 3, 7, 20'sd1000, 20'sd0, 1'b1));
        stage_hit(make_hit(SEC_TOP, 5, 2, -20'sd3000, 20'sd0, 1'b1));
        stage_hit(make_hit(SEC_BOTTOM, 9, 30, 20'sd77, 20'sd0, 1'b1));
        stage_hit(make_hit(SEC_LEFT, 1, 4, 20'sd0, 20'sd5000, 1'b1));
        stage_hit(make_hit(SEC_RIGHT, 60, 11, 20'sd0, -20'sd5000, 1'b1));
        stage_hit(make_hit(SEC_BACK, 0, 0, 20'sd0, 20'sd0, 1'b0));
        stage_hit(make_hit(SEC_TOP, 1, 1, 20'sd10, 20'sd10, 1'b0));
        stage_hit(make_hit(SEC_BOTTOM, 2, 2, 20'sd20, 20'sd20, 1'b0));
        stage_hit(make_hit(SEC_LEFT, 3, 3, 20'sd30, 20'sd30, 1'b0));
        stage_hit(make_hit(SEC_RIGHT, 4, 4, 20'sd40, 20'sd40, 1'b1));
        stage_hit(make_hit(3'd5, 10, 10, 20'sd0, 20'sd0, 1'b0));
        stage_hit(make_hit(SEC_BACK, 10, 10, 20'sd100, 20'sd0, 1'b0));
        stage_hit(make_hit(3'd6, 10, 10, 20'sd0, 20'sd0, 1'b1));
        stage_hit(make_hit(3'd7, 0, 0, 20'sd0, 20'sd0, 1'b1));
        stage_hit(make_hit(SEC_BACK, 127, 31, -20'sd524288, 20'sd524287, 1'b0));
        stage_hit(make_hit(SEC_LEFT, 127, 31, -20'sd524288, 20'sd524287, 1'b1));
        stage_hit(make_hit(SEC_TOP, 0, 0, 20'sd524287, -20'sd524288, 1'b0));
        stage_hit(make_hit(SEC_RIGHT, 127, 0, 20'sd524287, -20'sd524288, 1'b1));
        stage_hit(make_hit(SEC_BOTTOM, 127, 31, -20'sd1, -20'sd1, 1'b1));
        drain();

        // Random settings, with the long receiver hold in the middle of it.
        write_all('{$urandom_range(1, 65535), $urandom_range(1, 65535),
                    $urandom_range(1, 65535), $urandom_range(1, 65535)},
                  '{$urandom_range(0, 131071), $urandom_range(0, 131071),
                    $urandom_range(0, 131071), $urandom_range(0, 131071)});
        queue_random_clusters(160);
        repeat (200) @(posedge i_clk);
        hold_request = 1'b1;
        drain();

        // Smallest lengths and origins.
        write_all('{1, 1, 1, 1}, '{0, 0, 0, 0});
        queue_random_clusters(140);
        drain();

        // Largest lengths and origins.
        write_all('{65535, 65535, 65535, 65535}, '{131071, 131071, 131071, 131071});
        queue_random_clusters(140);
        drain();

        // Realistic detector settings, close to the defaults.
        write_all('{$urandom_range(100, 400), $urandom_range(800, 3200),
                    $urandom_range(400, 1000), $urandom_range(400, 3200)},
                  '{$urandom_range(0, 20000), $urandom_range(0, 20000),
                    $urandom_range(0, 40000), $urandom_range(0, 20000)});
        queue_random_clusters(200);
        drain();

        // Mixed: small lengths with large origins.
        write_all('{$urandom_range(1, 16), $urandom_range(1, 16),
                    $urandom_range(1, 16), $urandom_range(1, 16)},
                  '{$urandom_range(100000, 131071), $urandom_range(100000, 131071),
                    $urandom_range(100000, 131071), $urandom_range(100000, 131071)});
        queue_random_clusters(140);
        drain();

        if (mismatches == 0) begin
            $display("calorimeter_hit_cluster_position_unit regression: pass");
        end else begin
            $display("calorimeter_hit_cluster_position_unit regression: fail");
        end
        $finish;
    end

endmodule
